@@ hdl/blpg_pkg.sv @@
package blpg_pkg;

  localparam int COORD_BITS  = 6;
  localparam int WIDTH_BITS  = 7;
  localparam int INDEX_BITS  = COORD_BITS + 3;
  localparam int ERR_W       = COORD_BITS + 3;
  localparam int MAX_COLS    = 1 << COORD_BITS;
  localparam int SAT_W       = (COORD_BITS + 1 > WIDTH_BITS) ? COORD_BITS + 1 : WIDTH_BITS;
  localparam int PROD_W      = COORD_BITS + SAT_W;

  localparam logic [WIDTH_BITS-1:0] WIDTH_RESET = WIDTH_BITS'(64);

  typedef logic [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    coord_t start_x;
    coord_t start_y;
    coord_t end_x;
    coord_t end_y;
    logic   pixel_value;
  } request_t;

  typedef struct packed {
    coord_t                pixel_x;
    coord_t                pixel_y;
    logic [INDEX_BITS-1:0] byte_index;
    logic [2:0]            bit_position;
    logic                  write_value;
    logic                  last_pixel;
  } result_t;

  typedef struct packed {
    logic load;
    logic step;
  } cmd_t;

  typedef struct packed {
    logic last;
  } status_t;

endpackage

@@ hdl/blpg_ctrl.sv @@
module blpg_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  blpg_pkg::status_t status_i,
  output blpg_pkg::cmd_t   cmd_o,
  output logic             busy_o
);

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_e;

  state_e state_q;
  state_e state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o.load = 1'b0;
    cmd_o.step = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_RUN;
        end
      end
      ST_RUN: begin
        cmd_o.step = 1'b1;
        if (status_i.last) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q == ST_RUN);

  a_last_ends_run : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN && status_i.last) |=> (state_q == ST_IDLE))
    else $error("run did not end after last pixel");

  a_start_enters_run : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE && start_i) |=> (state_q == ST_RUN))
    else $error("accepted request did not start a run");

endmodule

@@ hdl/blpg_datapath.sv @@
module blpg_datapath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  blpg_pkg::cmd_t                      cmd_i,
  output blpg_pkg::status_t                   status_o,
  input  blpg_pkg::request_t                  req_i,
  input  logic                                cfg_we_i,
  input  logic [blpg_pkg::WIDTH_BITS-1:0]     cfg_data_i,
  output blpg_pkg::result_t                   result_o,
  output logic                                result_strobe_o
);

  blpg_pkg::coord_t x_q, y_q, xe_q, ye_q, dx_q, dy_q;
  blpg_pkg::coord_t dx_d, dy_d;
  logic             sx_dec_q, sy_dec_q, val_q;
  logic signed [blpg_pkg::ERR_W-1:0] err_q, err_d, dx_s, dy_s;
  logic signed [blpg_pkg::ERR_W:0]   e2, dx_e, dy_e;
  logic             step_x, step_y, last;
  logic [blpg_pkg::WIDTH_BITS-1:0]   width_q;
  logic [blpg_pkg::SAT_W-1:0]        width_ext, width_sat;
  logic [blpg_pkg::PROD_W-1:0]       index_full;
  blpg_pkg::coord_t page;
  blpg_pkg::result_t result_q;
  logic             strobe_q;

  // request setup
  assign dx_d = (req_i.end_x > req_i.start_x) ? req_i.end_x - req_i.start_x
                                              : req_i.start_x - req_i.end_x;
  assign dy_d = (req_i.end_y > req_i.start_y) ? req_i.end_y - req_i.start_y
                                              : req_i.start_y - req_i.end_y;

  // error term step
  assign dx_s   = signed'(blpg_pkg::ERR_W'(dx_q));
  assign dy_s   = signed'(blpg_pkg::ERR_W'(dy_q));
  assign dx_e   = signed'((blpg_pkg::ERR_W + 1)'(dx_q));
  assign dy_e   = signed'((blpg_pkg::ERR_W + 1)'(dy_q));
  assign e2     = signed'({err_q, 1'b0});
  assign step_x = (e2 > -dy_e);
  assign step_y = (e2 < dx_e);
  assign err_d  = err_q - (step_x ? dy_s : '0) + (step_y ? dx_s : '0);
  assign last   = (x_q == xe_q) && (y_q == ye_q);

  assign status_o.last = last;

  // framebuffer address
  assign width_ext  = blpg_pkg::SAT_W'(width_q);
  assign width_sat  = (width_ext > blpg_pkg::SAT_W'(blpg_pkg::MAX_COLS))
                    ? blpg_pkg::SAT_W'(blpg_pkg::MAX_COLS) : width_ext;
  assign page       = y_q >> 3;
  assign index_full = blpg_pkg::PROD_W'(page) * blpg_pkg::PROD_W'(width_sat)
                    + blpg_pkg::PROD_W'(x_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= blpg_pkg::WIDTH_RESET;
      strobe_q <= 1'b0;
    end else begin
      strobe_q <= cmd_i.step;
      if (cfg_we_i) begin
        width_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      x_q      <= req_i.start_x;
      y_q      <= req_i.start_y;
      xe_q     <= req_i.end_x;
      ye_q     <= req_i.end_y;
      dx_q     <= dx_d;
      dy_q     <= dy_d;
      sx_dec_q <= !(req_i.start_x < req_i.end_x);
      sy_dec_q <= !(req_i.start_y < req_i.end_y);
      val_q    <= req_i.pixel_value;
      err_q    <= signed'(blpg_pkg::ERR_W'(dx_d)) - signed'(blpg_pkg::ERR_W'(dy_d));
    end else if (cmd_i.step) begin
      if (step_x) begin
        x_q <= sx_dec_q ? x_q - 1'b1 : x_q + 1'b1;
      end
      if (step_y) begin
        y_q <= sy_dec_q ? y_q - 1'b1 : y_q + 1'b1;
      end
      err_q <= err_d;
    end
    if (cmd_i.step) begin
      result_q.pixel_x      <= x_q;
      result_q.pixel_y      <= y_q;
      result_q.byte_index   <= index_full[blpg_pkg::INDEX_BITS-1:0];
      result_q.bit_position <= y_q[2:0];
      result_q.write_value  <= val_q;
      result_q.last_pixel   <= last;
    end
  end

  assign result_o        = result_q;
  assign result_strobe_o = strobe_q;

  a_step_strobes : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.step |=> strobe_q)
    else $error("step without result strobe");

  a_step_moves : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.step && !last) |=> (x_q != $past(x_q) || y_q != $past(y_q)))
    else $error("step left the pixel in place");

  a_last_is_end : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_q && result_q.last_pixel) |->
      (result_q.pixel_x == xe_q && result_q.pixel_y == ye_q))
    else $error("last pixel is not the end point");

endmodule

@@ hdl/bresenham_line_pixel_generator.sv @@
// channel   direction  handshake               payload
// request   in         start / busy            req_i (start and end points, pixel value)
// result    out        result_strobe_o         result_o (pixel, byte index, bit, value, last)
// config    in         cfg_valid_i/cfg_ready_o cfg_data_i (display width)
//
// a line of n = max(|dx|,|dy|) + 1 pixels is drawn with busy high,
// one bresenham step per cycle; the request is loaded in idle, where busy is low
// each result is registered from a run-state step, then one per cycle
// reset: asynchronous active low, idle, display width 64
// results are never stalled; config is taken while not busy
module bresenham_line_pixel_generator (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  blpg_pkg::request_t              req_i,
  output blpg_pkg::result_t               result_o,
  output logic                            result_strobe_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [blpg_pkg::WIDTH_BITS-1:0] cfg_data_i
);

  blpg_pkg::cmd_t    cmd;
  blpg_pkg::status_t status;

  assign cfg_ready_o = !busy;

  blpg_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy)
  );

  blpg_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .req_i           (req_i),
    .cfg_we_i        (cfg_valid_i && cfg_ready_o),
    .cfg_data_i      (cfg_data_i),
    .result_o        (result_o),
    .result_strobe_o (result_strobe_o)
  );

endmodule

@@ sim/tb_top.sv @@
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT  = 2000;
  localparam int PHASE_LINES  = 80;
  localparam int NUM_PHASES   = 5;
  localparam int SETTLE_TICKS = 4;

  logic                            clk_i = 1'b0;
  logic                            rst_ni = 1'b0;
  logic                            start = 1'b0;
  logic                            busy;
  blpg_pkg::request_t              req_i = '0;
  blpg_pkg::result_t               result_o;
  logic                            result_strobe_o;
  logic                            cfg_valid_i = 1'b0;
  logic                            cfg_ready_o;
  logic [blpg_pkg::WIDTH_BITS-1:0] cfg_data_i = '0;

  blpg_pkg::result_t     expected_pixels[$];
  blpg_pkg::result_t     want_pixel;
  int unsigned           fb_width = 64;
  int                    idle_pct = 10;
  int                    mismatches = 0;
  int                    stall_cycles = 0;

  bresenham_line_pixel_generator uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .req_i           (req_i),
    .result_o        (result_o),
    .result_strobe_o (result_strobe_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i)
  );

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  // walk the line and queue every pixel it visits
  task automatic plot_line(input blpg_pkg::request_t r);
    int x, y, xe, ye, dx, dy, sx, sy, err, e2, n, w;
    logic at_end;
    blpg_pkg::result_t p;
    x = int'(r.start_x);
    y = int'(r.start_y);
    xe = int'(r.end_x);
    ye = int'(r.end_y);
    w = (fb_width > blpg_pkg::MAX_COLS) ? blpg_pkg::MAX_COLS : int'(fb_width);
    dx = (xe > x) ? xe - x : x - xe;
    dy = (ye > y) ? ye - y : y - ye;
    sx = (x < xe) ? 1 : -1;
    sy = (y < ye) ? 1 : -1;
    err = dx - dy;
    n = 0;
    while (n < blpg_pkg::MAX_COLS) begin
      at_end = (x == xe) && (y == ye);
      p.pixel_x = blpg_pkg::coord_t'(x);
      p.pixel_y = blpg_pkg::coord_t'(y);
      p.byte_index = blpg_pkg::INDEX_BITS'((int'(p.pixel_y) / 8) * w + int'(p.pixel_x));
      p.bit_position = p.pixel_y[2:0];
      p.write_value = r.pixel_value;
      p.last_pixel = at_end;
      expected_pixels.push_back(p);
      n++;
      if (at_end) break;
      e2 = err * 2;
      if (e2 > -dy) begin
        err -= dy;
        x += sx;
      end
      if (e2 < dx) begin
        err += dx;
        y += sy;
      end
    end
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && result_strobe_o) begin
      if (expected_pixels.size() == 0) begin
        $error("unexpected pixel x=%0d y=%0d", result_o.pixel_x, result_o.pixel_y);
        mismatches++;
        $display("*** FAILED ***");
        $finish;
      end else begin
        want_pixel = expected_pixels.pop_front();
        check_field("pixel_x", 32'(want_pixel.pixel_x), 32'(result_o.pixel_x));
        check_field("pixel_y", 32'(want_pixel.pixel_y), 32'(result_o.pixel_y));
        check_field("byte_index", 32'(want_pixel.byte_index), 32'(result_o.byte_index));
        check_field("bit_position", 32'(want_pixel.bit_position),
                    32'(result_o.bit_position));
        check_field("write_value", 32'(want_pixel.write_value), 32'(result_o.write_value));
        check_field("last_pixel", 32'(want_pixel.last_pixel), 32'(result_o.last_pixel));
      end
    end
  end

  always @(posedge clk_i) begin
    if ((start && !busy) || result_strobe_o || (cfg_valid_i && cfg_ready_o)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic send_line(input blpg_pkg::request_t r);
    start <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (busy);
    plot_line(r);
    if ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
  endtask

  task automatic stop_requests();
    start <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic drain_lines();
    stop_requests();
    while (expected_pixels.size() != 0) @(posedge clk_i);
    repeat (SETTLE_TICKS) @(posedge clk_i);
  endtask

  task automatic write_width(input int unsigned w);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= blpg_pkg::WIDTH_BITS'(w);
    do @(posedge clk_i); while (!cfg_ready_o);
    fb_width = w;
    cfg_valid_i <= 1'b0;
  endtask

  function automatic blpg_pkg::request_t make_line(input int x0, input int y0, input int x1,
                                                   input int y1, input bit val);
    blpg_pkg::request_t r;
    r.start_x = blpg_pkg::coord_t'(x0);
    r.start_y = blpg_pkg::coord_t'(y0);
    r.end_x = blpg_pkg::coord_t'(x1);
    r.end_y = blpg_pkg::coord_t'(y1);
    r.pixel_value = val;
    return r;
  endfunction

  function automatic int near_coord(input int c);
    int v;
    v = c + int'($urandom_range(0, 6)) - 3;
    return (v < 0) ? 0 : (v > blpg_pkg::MAX_COLS - 1) ? blpg_pkg::MAX_COLS - 1 : v;
  endfunction

  function automatic blpg_pkg::request_t rand_line();
    blpg_pkg::request_t r;
    int kind;
    kind = int'($urandom_range(0, 7));
    r.start_x = blpg_pkg::coord_t'($urandom_range(0, blpg_pkg::MAX_COLS - 1));
    r.start_y = blpg_pkg::coord_t'($urandom_range(0, blpg_pkg::MAX_COLS - 1));
    r.pixel_value = 1'($urandom_range(0, 1));
    if (kind == 0) begin
      r.end_x = r.start_x;
      r.end_y = r.start_y;
    end else if (kind < 3) begin
      r.end_x = blpg_pkg::coord_t'(near_coord(int'(r.start_x)));
      r.end_y = blpg_pkg::coord_t'(near_coord(int'(r.start_y)));
    end else begin
      r.end_x = blpg_pkg::coord_t'($urandom_range(0, blpg_pkg::MAX_COLS - 1));
      r.end_y = blpg_pkg::coord_t'($urandom_range(0, blpg_pkg::MAX_COLS - 1));
    end
    return r;
  endfunction

  // default width, both diagonals both ways, horizontal, vertical, shallow and steep lines, edges of the field
  task automatic test_octants();
    send_line(make_line(0, 0, 63, 63, 1'b1));
    send_line(make_line(63, 63, 0, 0, 1'b0));
    send_line(make_line(0, 63, 63, 0, 1'b1));
    send_line(make_line(63, 0, 0, 63, 1'b0));
    send_line(make_line(0, 5, 63, 5, 1'b1));
    send_line(make_line(40, 0, 40, 63, 1'b1));
    send_line(make_line(10, 20, 50, 27, 1'b0));
    send_line(make_line(50, 27, 10, 20, 1'b1));
    send_line(make_line(12, 2, 19, 60, 1'b1));
    send_line(make_line(0, 0, 0, 0, 1'b1));
    send_line(make_line(63, 63, 63, 63, 1'b0));
    drain_lines();
  endtask

  // zero width, saturation above the column count, and plain values
  task automatic test_widths();
    int unsigned widths[7] = '{0, 1, 8, 63, 65, 127, 64};
    foreach (widths[i]) begin
      write_width(widths[i]);
      send_line(make_line(0, 0, 63, 63, i[0]));
      send_line(make_line(63, 0, 0, 63, !i[0]));
      drain_lines();
    end
  endtask

  task automatic test_random_lines();
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      write_width((ph == 0) ? 64 : $urandom_range(0, 127));
      idle_pct = (ph == 2) ? 0 : 10;
      for (int i = 0; i < PHASE_LINES; i++) begin
        send_line(rand_line());
      end
      drain_lines();
    end
    idle_pct = 10;
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_octants();
    test_widths();
    test_random_lines();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0 && expected_pixels.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

@@ files.f @@
hdl/blpg_pkg.sv
hdl/blpg_ctrl.sv
hdl/blpg_datapath.sv
hdl/bresenham_line_pixel_generator.sv
sim/tb_top.sv
